/* src/esd_pkg.sv */
// Package for the escape sequence decoder: decode modes, status codes,
// character constants, shared types and the escape lookup functions.
// No dependencies.
package esd_pkg;

    // Decode modes
    localparam logic [2:0] MODE_TEXT = 3'd0;
    localparam logic [2:0] MODE_ESC  = 3'd1;
    localparam logic [2:0] MODE_OCT  = 3'd2;
    localparam logic [2:0] MODE_HEX  = 3'd3;
    localparam logic [2:0] MODE_DROP = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_BAD_OCT = 2'd2;
    localparam logic [1:0] ST_BAD_HEX = 2'd3;

    // Characters
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_V   = 8'h76;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_QUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;

    localparam logic [8:0] BYTE_MAX_VALUE = 9'd255;

    // Decoder state
    typedef struct packed {
        logic [2:0] mode;
        logic [8:0] value;
        logic [1:0] count;
    } t_dec_state;

    // One result item
    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] status;
        logic       final_result;
    } t_result;

    // Results caused by one input item; second is valid only with the first
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result res0;
        t_result res1;
    } t_dec_out;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } t_esc_lookup;

    typedef struct packed {
        logic       hit;
        logic [3:0] value;
    } t_hex_lookup;

    // Map a simple escape letter to its byte
    function automatic t_esc_lookup simple_escape(input logic [7:0] c);
        t_esc_lookup r;
        r.hit = 1'b1;
        case (c)
            CH_LOWER_N:   r.value = 8'd10;
            CH_LOWER_A:   r.value = 8'd7;
            CH_LOWER_V:   r.value = 8'd11;
            CH_LOWER_T:   r.value = 8'd9;
            CH_LOWER_R:   r.value = 8'd13;
            CH_LOWER_B:   r.value = 8'd8;
            CH_BACKSLASH: r.value = 8'd92;
            CH_QUOTE:     r.value = 8'd39;
            CH_DQUOTE:    r.value = 8'd34;
            CH_QUESTION:  r.value = 8'd63;
            default: begin
                r.hit   = 1'b0;
                r.value = 8'd0;
            end
        endcase
        return r;
    endfunction

    // Map a hex digit character to its value
    function automatic t_hex_lookup hex_digit(input logic [7:0] c);
        t_hex_lookup r;
        r.hit   = 1'b1;
        r.value = 4'd0;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            r.value = c[3:0];
        end else if (c inside {[CH_LOWER_A:CH_LOWER_F]} ||
                     c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
            r.value = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return (c inside {[CH_ZERO:CH_SEVEN]});
    endfunction

endpackage

/* src/esd_decode.sv */
// Decode step: from the current decoder state and one input byte, form the
// next state and up to two result items. Pure combinational logic.
// Depends on esd_pkg.
module esd_decode import esd_pkg::*; (
    input  t_dec_state i_state,
    input  logic [7:0] i_char,
    input  logic       i_eos,
    output t_dec_state o_state,
    output t_dec_out   o_out
);

    t_esc_lookup w_esc;
    t_hex_lookup w_hex;
    logic [8:0]  w_oct_value;
    logic [8:0]  w_hex_value;
    logic [1:0]  w_count_inc;

    assign w_esc       = simple_escape(i_char);
    assign w_hex       = hex_digit(i_char);
    assign w_oct_value = {i_state.value[5:0], i_char[2:0]};
    assign w_hex_value = {i_state.value[4:0], w_hex.value};
    assign w_count_inc = i_state.count + 2'd1;

    always_comb begin
        o_state    = i_state;
        o_out      = '0;

        case (i_state.mode)
            MODE_ESC: begin
                if (w_esc.hit) begin
                    o_out.valid0        = 1'b1;
                    o_out.res0.out_char = w_esc.value;
                    o_out.res0.status   = ST_OK;
                    o_state.mode        = MODE_TEXT;
                end else if (is_octal(i_char)) begin
                    o_state.value = {6'd0, i_char[2:0]};
                    o_state.count = 2'd1;
                    o_state.mode  = MODE_OCT;
                    if (i_eos) begin
                        o_out.valid0        = 1'b1;
                        o_out.res0.out_char = {5'd0, i_char[2:0]};
                        o_out.res0.status   = ST_OK;
                    end
                end else if (i_char == CH_LOWER_X) begin
                    o_state.value = '0;
                    o_state.count = '0;
                    o_state.mode  = MODE_HEX;
                    if (i_eos) begin
                        o_out.valid0      = 1'b1;
                        o_out.res0.status = ST_BAD_HEX;
                    end
                end else begin
                    o_out.valid0      = 1'b1;
                    o_out.res0.status = ST_UNKNOWN;
                    o_state.mode      = MODE_DROP;
                end
            end
            MODE_OCT: begin
                if (is_octal(i_char)) begin
                    o_state.value = w_oct_value;
                    o_state.count = w_count_inc;
                    if (w_count_inc == 2'd3 || i_eos) begin
                        o_out.valid0 = 1'b1;
                        if (w_oct_value > BYTE_MAX_VALUE) begin
                            o_out.res0.status = ST_BAD_OCT;
                            o_state.mode      = MODE_DROP;
                        end else begin
                            o_out.res0.out_char = w_oct_value[7:0];
                            o_out.res0.status   = ST_OK;
                            o_state.mode        = MODE_TEXT;
                        end
                    end
                end else begin
                    // Flush the value, then treat the byte as text
                    o_out.valid0        = 1'b1;
                    o_out.res0.out_char = i_state.value[7:0];
                    o_out.res0.status   = ST_OK;
                    o_state.mode        = MODE_TEXT;
                    if (i_char == CH_BACKSLASH && !i_eos) begin
                        o_state.mode = MODE_ESC;
                    end else begin
                        o_out.valid1        = 1'b1;
                        o_out.res1.out_char = i_char;
                        o_out.res1.status   = ST_OK;
                    end
                end
            end
            MODE_HEX: begin
                if (w_hex.hit) begin
                    o_state.value = w_hex_value;
                    o_state.count = w_count_inc;
                    if (w_count_inc >= 2'd2 || i_eos) begin
                        o_out.valid0        = 1'b1;
                        o_out.res0.out_char = w_hex_value[7:0];
                        o_out.res0.status   = ST_OK;
                        o_state.mode        = MODE_TEXT;
                    end
                end else if (i_state.count == 2'd0) begin
                    o_out.valid0      = 1'b1;
                    o_out.res0.status = ST_BAD_HEX;
                    o_state.mode      = MODE_DROP;
                end else begin
                    o_out.valid0        = 1'b1;
                    o_out.res0.out_char = i_state.value[7:0];
                    o_out.res0.status   = ST_OK;
                    o_state.mode        = MODE_TEXT;
                    if (i_char == CH_BACKSLASH && !i_eos) begin
                        o_state.mode = MODE_ESC;
                    end else begin
                        o_out.valid1        = 1'b1;
                        o_out.res1.out_char = i_char;
                        o_out.res1.status   = ST_OK;
                    end
                end
            end
            MODE_DROP: begin
                // Drop bytes until end of string
            end
            default: begin
                o_state.mode = MODE_TEXT;
                if (i_char == CH_BACKSLASH && !i_eos) begin
                    o_state.mode = MODE_ESC;
                end else begin
                    o_out.valid0        = 1'b1;
                    o_out.res0.out_char = i_char;
                    o_out.res0.status   = ST_OK;
                end
            end
        endcase

        // End of string: mark the last result and clear digit state
        if (i_eos) begin
            o_state = '{mode: MODE_TEXT, value: '0, count: '0};
            if (o_out.valid1) begin
                o_out.res1.final_result = 1'b1;
            end else if (o_out.valid0) begin
                o_out.res0.final_result = 1'b1;
            end
        end
    end

endmodule

/* src/esd_out_fifo.sv */
// Four-entry result queue: takes up to two result items per cycle, hands
// out one per cycle on a valid/ready channel. Depends on esd_pkg.
module esd_out_fifo import esd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dec_out   i_push,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_head
);

    t_result     r_mem [4];
    logic [1:0]  r_wr_ptr;
    logic [1:0]  r_rd_ptr;
    logic [2:0]  r_count;
    logic [1:0]  n_wr_ptr;
    logic [1:0]  n_rd_ptr;
    logic [2:0]  n_count;
    logic        w_pop;
    logic [2:0]  w_push_num;

    assign o_valid    = (r_count != 3'd0);
    assign o_room     = (r_count <= 3'd2);
    assign o_head     = r_mem[r_rd_ptr];
    assign w_pop      = o_valid && i_ready;
    assign w_push_num = {2'd0, i_push.valid0} + {2'd0, i_push.valid1};

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr + w_push_num[1:0];
        n_rd_ptr = r_rd_ptr + {1'b0, w_pop};
        n_count  = r_count + w_push_num - {2'd0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed items in order
    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.valid1) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push.res1;
        end
    end

endmodule

/* src/escape_sequence_decoder.sv */
// Top level of the C string escape decoder.
// Depends on esd_pkg, esd_decode and esd_out_fifo.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one string byte per item with
//   an end-of-string flag. Output channel (o_valid / i_ready) carries decoded
//   bytes with a status code and a flag on the last result of a string.
//   An input item yields zero, one or two result items; errors put the
//   decoder into a drop state that discards bytes until end of string.
//   A result item enters the result queue when its input item is accepted.
//   The decoder takes one input item per cycle while o_ready is high, set by
//   the single decode step between the state register and the four-entry
//   result queue. o_ready is high while the queue has room for two results,
//   so with a receiver that takes one item per cycle input flows at full
//   rate; a two-result burst is absorbed by the queue.
//   When the receiver stalls, results stay in the queue and o_ready drops
//   once fewer than two entries are free.
//   Reset (synchronous, active low) returns the decoder to text mode with
//   cleared digit state and empties the queue.
module escape_sequence_decoder import esd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_end_of_string,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic [1:0] o_status,
    output logic       o_final_result
);

    t_dec_state r_state;
    t_dec_state n_state;
    t_dec_out   w_dec;
    t_dec_out   w_push;
    t_result    w_head;
    logic       w_accept;

    assign w_accept = i_valid && o_ready;

    esd_decode u_decode (
        .i_state (r_state),
        .i_char  (i_in_char),
        .i_eos   (i_end_of_string),
        .o_state (n_state),
        .o_out   (w_dec)
    );

    // Push results only for an accepted item
    always_comb begin
        w_push        = w_dec;
        w_push.valid0 = w_dec.valid0 && w_accept;
        w_push.valid1 = w_dec.valid1 && w_accept;
    end

    // Hold decoder state between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_TEXT, value: '0, count: '0};
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    esd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_head  (w_head)
    );

    assign o_out_char     = w_head.out_char;
    assign o_status       = w_head.status;
    assign o_final_result = w_head.final_result;

endmodule
